>>> sv/ped_pkg.sv
// Shared types, character constants and the hex digit decoder of the percent-escape decoder.
package ped_pkg;

  localparam logic [7:0] PctSign = 8'h25;  // '%'
  localparam logic [7:0] Dig0    = 8'h30;  // '0'
  localparam logic [7:0] Dig9    = 8'h39;  // '9'
  localparam logic [7:0] LowA    = 8'h61;  // 'a'
  localparam logic [7:0] LowF    = 8'h66;  // 'f'
  localparam logic [7:0] UpA     = 8'h41;  // 'A'
  localparam logic [7:0] UpF     = 8'h46;  // 'F'
  localparam logic [7:0] HexTen  = 8'd10;
  localparam int unsigned NibW   = 4;

  localparam int unsigned MaxOut = 3;  // bytes one request can cause

  // Escape progress: nothing held, the percent sign held, sign and first digit held.
  typedef enum logic [2:0] {
    PendNone  = 3'b001,
    PendPct   = 3'b010,
    PendDigit = 3'b100
  } ped_pend_e;

  // One queued job: the bytes a request caused, how many, and whether it ended a string.
  typedef struct packed {
    logic [MaxOut-1:0][7:0] bytes;
    logic [1:0]             cnt;
    logic                   last;
  } ped_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ped_q_stat_t;

  // Returns {valid, value} for one ASCII hex digit of either letter case.
  function automatic logic [NibW:0] hex_decode(logic [7:0] c);
    logic [7:0] lo_v;
    logic [7:0] up_v;
    lo_v = c - LowA + HexTen;
    up_v = c - UpA + HexTen;
    if (c >= Dig0 && c <= Dig9) begin
      return {1'b1, c[NibW-1:0]};
    end else if (c >= LowA && c <= LowF) begin
      return {1'b1, lo_v[NibW-1:0]};
    end else if (c >= UpA && c <= UpF) begin
      return {1'b1, up_v[NibW-1:0]};
    end
    return '0;
  endfunction

endpackage

>>> sv/ped_in_if.sv
// Request channel of the percent-escape decoder: one raw byte and its end-of-string mark.
interface ped_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

>>> sv/ped_out_if.sv
// Result channel of the percent-escape decoder: one output byte with its run and string marks.
interface ped_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       string_end;

  modport source (output valid, output out_byte, output run_end, output string_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_end, input string_end,
                  output ready);
endinterface

>>> sv/ped_front.sv
// Front end: takes requests, tracks the open escape, queues each request's bytes.
module ped_front import ped_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        in_ready_o,
  input  ped_q_stat_t q_stat_i,
  output logic        push_o,
  output ped_cmd_t    cmd_o
);

  ped_pend_e  pend_q, pend_d;
  logic [7:0] held_q;
  logic       accept;
  logic [NibW:0] cur_hex;
  logic [NibW:0] held_hex;
  logic [MaxOut-1:0][7:0] bytes;
  logic [1:0] n;
  logic       hold_now;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign cur_hex    = hex_decode(in_byte_i);
  assign held_hex   = hex_decode(held_q);

  always_comb begin
    bytes    = '0;
    n        = 2'd0;
    pend_d   = PendNone;
    hold_now = 1'b0;
    unique case (pend_q)
      PendPct: begin
        if (cur_hex[NibW]) begin
          hold_now = 1'b1;
          pend_d   = PendDigit;
        end else begin
          bytes[n] = PctSign;
          n        = n + 2'd1;
          if (in_byte_i == PctSign) begin
            pend_d = PendPct;
          end else begin
            bytes[n] = in_byte_i;
            n        = n + 2'd1;
          end
        end
      end
      PendDigit: begin
        if (cur_hex[NibW]) begin
          bytes[n] = {held_hex[NibW-1:0], cur_hex[NibW-1:0]};
          n        = n + 2'd1;
        end else begin
          bytes[0] = PctSign;
          bytes[1] = held_q;
          n        = 2'd2;
          if (in_byte_i == PctSign) begin
            pend_d = PendPct;
          end else begin
            bytes[n] = in_byte_i;
            n        = n + 2'd1;
          end
        end
      end
      default: begin
        if (in_byte_i == PctSign) begin
          pend_d = PendPct;
        end else begin
          bytes[n] = in_byte_i;
          n        = n + 2'd1;
        end
      end
    endcase
    // The string ends: whatever is still held goes out literally.
    if (in_last_i) begin
      if (pend_d == PendPct) begin
        bytes[n] = PctSign;
        n        = n + 2'd1;
      end else if (pend_d == PendDigit) begin
        // Only reached when this very byte became the held digit.
        bytes[0] = PctSign;
        bytes[1] = in_byte_i;
        n        = 2'd2;
      end
      pend_d = PendNone;
    end
  end

  assign push_o    = accept && (n != 2'd0);
  assign cmd_o     = '{bytes: bytes, cnt: n, last: in_last_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= PendNone;
    end else if (accept) begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && hold_now) begin
      held_q <= in_byte_i;
    end
  end

endmodule

>>> sv/ped_queue.sv
// Two-entry job queue between the front end and the output sequencer.
module ped_queue import ped_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  ped_cmd_t    cmd_i,
  input  logic        pop_i,
  output ped_cmd_t    head_o,
  output ped_q_stat_t stat_o
);

  ped_cmd_t   mem_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;

  assign head_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

>>> sv/ped_back.sv
// Back end: walks the head job, when unstalled, a byte a cycle to byte_q.
module ped_back import ped_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ped_cmd_t    head_i,
  input  ped_q_stat_t q_stat_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        run_end_o,
  output logic        string_end_o
);

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       run_q, str_q;
  logic       load;
  logic       is_end;

  assign load   = !valid_q || out_ready_i;
  assign is_end = (idx_q == head_i.cnt - 2'd1);

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = !q_stat_i.empty;
      if (!q_stat_i.empty) begin
        if (is_end) begin
          pop_o = 1'b1;
          idx_d = 2'd0;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && !q_stat_i.empty) begin
      byte_q <= head_i.bytes[idx_q];
      run_q  <= is_end;
      str_q  <= is_end && head_i.last;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign run_end_o    = run_q;
  assign string_end_o = str_q;

endmodule

>>> sv/percent_escape_decoder.sv
// Top level of the streaming percent-escape decoder.
//
//   Channel  Dir  Payload                          Handshake
//   in_i     in   in_byte[8], in_last              valid/ready, taken when both high
//   out_o    out  out_byte[8], run_end, string_end valid/ready, taken when both high
//
// A request is taken whenever the job queue has room; it causes zero to three
// output bytes, which leave one per cycle from a registered output stage
// while the output is ready. The output sequencer is the limit: it sends
// the bytes of each request one after another, so plain text runs at one
// byte per cycle. Reset is asynchronous and active low; it clears
// the escape state, the queue pointers and the output valid. A stall on the
// output fills the two-entry queue and only then drops in_i.ready.
module percent_escape_decoder import ped_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ped_in_if.sink    in_i,
  ped_out_if.source out_o
);

  // Jobs built by the front end, queue status, and the pop from the back end.
  ped_cmd_t    cmd;
  ped_cmd_t    head;
  ped_q_stat_t q_stat;
  logic        push;
  logic        pop;

  // The front end tracks the escape in progress and turns each request that
  // releases bytes into one job holding every byte that the request releases.
  ped_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_byte_i  (in_i.in_byte),
    .in_last_i  (in_i.in_last),
    .in_ready_o (in_i.ready),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  // Short queue so that the front end keeps taking requests while the back
  // end is busy with a multi-byte job or held by the output.
  ped_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  // The back end emits the head job one byte at a time and marks the last
  // byte of each job, and of each string.
  ped_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .q_stat_i     (q_stat),
    .pop_o        (pop),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_byte_o   (out_o.out_byte),
    .run_end_o    (out_o.run_end),
    .string_end_o (out_o.string_end)
  );

  // A request that ends a string always releases at least one byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && in_i.in_last |-> push)
    else $error("string end request produced no job");

  // The back end never pops an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("pop from empty job queue");

  // The front end never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("push into full job queue");

  // A string end mark only ever appears on the last byte of a job.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.string_end |-> out_o.run_end)
    else $error("string end without run end");

endmodule
